[hw/rtl/bsf_pkg.sv]
// bsf_pkg: shared constants, command codes and controller/datapath structs
// for the balance state-feedback block
// no dependencies
package bsf_pkg;

    localparam int GYRO_BITS_DEF  = 10;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 5;
    localparam int SP_W    = 24;
    localparam int GAIN_W  = 32;
    localparam int TILT_W  = 48;
    localparam int FRAC_W  = 24;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PCT_W   = 8;
    localparam int Q16_W   = 16;

    localparam logic [15:0]       RST_GYRO_OFFSET   = 16'd595;
    localparam logic [SP_W-1:0]   RST_SAMPLE_PERIOD = 24'd57848;
    localparam logic [GAIN_W-1:0] RST_GAIN_ANGLE    = 32'd2162557;
    localparam logic [GAIN_W-1:0] RST_GAIN_RATE     = 32'd122278;
    localparam logic [GAIN_W-1:0] RST_GAIN_POSITION = 32'd14390;
    localparam logic [GAIN_W-1:0] RST_GAIN_VELOCITY = 32'd4038947;

    localparam logic signed [PROD_W-1:0] LIMIT_Q16 = PROD_W'(100 * 65536);
    localparam logic signed [PCT_W-1:0]  PCT_MAX   = 8'sd100;
    localparam logic signed [PCT_W-1:0]  PCT_MIN   = -8'sd100;

    // register indexes
    localparam logic [2:0] REG_GYRO_OFFSET   = 3'd0;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [2:0] REG_GAIN_ANGLE    = 3'd2;
    localparam logic [2:0] REG_GAIN_RATE     = 3'd3;
    localparam logic [2:0] REG_GAIN_POSITION = 3'd4;
    localparam logic [2:0] REG_GAIN_VELOCITY = 3'd5;

    // multiplier operand selection
    localparam logic [2:0] MUL_NONE    = 3'd0;
    localparam logic [2:0] MUL_RATE_SP = 3'd1;
    localparam logic [2:0] MUL_GR_RATE = 3'd2;
    localparam logic [2:0] MUL_GA_TH   = 3'd3;
    localparam logic [2:0] MUL_GA_TL   = 3'd4;
    localparam logic [2:0] MUL_GP_POS  = 3'd5;
    localparam logic [2:0] MUL_GV_VEL  = 3'd6;

    // accumulator operations on the registered product
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_CLEAR = 3'd1;
    localparam logic [2:0] ACC_TILT  = 3'd2;
    localparam logic [2:0] ACC_ADD   = 3'd3;
    localparam logic [2:0] ACC_ADDSH = 3'd4;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic [2:0] acc_op;
        logic       out_write;
    } bsf_cmd_t;

    typedef struct packed {
        logic out_free;
    } bsf_status_t;

endpackage

[hw/rtl/balance_state_feedback.sv]
// balance_state_feedback: top level of the balance state-feedback controller
// depends on bsf_pkg, bsf_regs, bsf_ctrl, bsf_dpath
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: gyro_raw, encoder_count
//  m_*      | out | m_tvalid/m_tready  | tdata: speed_percent; tuser: saturated
//  apb      | in  | psel/penable       | six config registers at 4*i
//
//  a result is written after the single shared 33x33 multiplier has stepped
//  through six products, and no new transaction is taken in the meantime
//  a new transaction is taken as soon as the sequencer is back in idle, even
//  while the previous result still waits in the output register
//  reset clears tilt angle, last encoder count and the output valid
//  a stalled output holds the sequencer in its last step until the slot frees
module balance_state_feedback #(
    parameter int GYRO_BITS  = bsf_pkg::GYRO_BITS_DEF,
    parameter int COUNT_BITS = bsf_pkg::COUNT_BITS_DEF,
    parameter int S_DATA_W   = ((GYRO_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_DATA_W-1:0]        s_tdata,   // gyro_raw, encoder_count
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bsf_pkg::PCT_W-1:0]  m_tdata,   // speed_percent
    output logic                       m_tuser,   // saturated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsf_pkg::ADDR_W-1:0] paddr,
    input  logic [bsf_pkg::CFG_W-1:0]  pwdata,
    output logic [bsf_pkg::CFG_W-1:0]  prdata,
    output logic                       pready
);
    import bsf_pkg::*;

    logic [GYRO_BITS-1:0] gyro_offset;
    logic [SP_W-1:0]      sample_period;
    logic [GAIN_W-1:0]    gain_angle;
    logic [GAIN_W-1:0]    gain_rate;
    logic [GAIN_W-1:0]    gain_position;
    logic [GAIN_W-1:0]    gain_velocity;
    bsf_cmd_t             cmd;
    bsf_status_t          status;

    bsf_regs #(
        .GYRO_BITS (GYRO_BITS)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .gyro_offset   (gyro_offset),
        .sample_period (sample_period),
        .gain_angle    (gain_angle),
        .gain_rate     (gain_rate),
        .gain_position (gain_position),
        .gain_velocity (gain_velocity)
    );

    bsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsf_dpath #(
        .GYRO_BITS  (GYRO_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .gyro_raw      (s_tdata[GYRO_BITS-1:0]),
        .encoder_count (s_tdata[GYRO_BITS+COUNT_BITS-1:GYRO_BITS]),
        .gyro_offset   (gyro_offset),
        .sample_period (sample_period),
        .gain_angle    (gain_angle),
        .gain_rate     (gain_rate),
        .gain_position (gain_position),
        .gain_velocity (gain_velocity),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .speed_percent (m_tdata),
        .saturated     (m_tuser)
    );

endmodule

[hw/rtl/bsf_regs.sv]
// bsf_regs: apb configuration registers (offset, period, four gains)
// depends on bsf_pkg
module bsf_regs #(
    parameter int GYRO_BITS = bsf_pkg::GYRO_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsf_pkg::ADDR_W-1:0] paddr,
    input  logic [bsf_pkg::CFG_W-1:0]  pwdata,
    output logic [bsf_pkg::CFG_W-1:0]  prdata,
    output logic                       pready,
    output logic [GYRO_BITS-1:0]       gyro_offset,
    output logic [bsf_pkg::SP_W-1:0]   sample_period,
    output logic [bsf_pkg::GAIN_W-1:0] gain_angle,
    output logic [bsf_pkg::GAIN_W-1:0] gain_rate,
    output logic [bsf_pkg::GAIN_W-1:0] gain_position,
    output logic [bsf_pkg::GAIN_W-1:0] gain_velocity
);
    import bsf_pkg::*;

    logic [GYRO_BITS-1:0] gyro_offset_reg;
    logic [SP_W-1:0]      sample_period_reg;
    logic [GAIN_W-1:0]    gain_angle_reg;
    logic [GAIN_W-1:0]    gain_rate_reg;
    logic [GAIN_W-1:0]    gain_position_reg;
    logic [GAIN_W-1:0]    gain_velocity_reg;
    logic [2:0]           index;
    logic                 wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_offset_reg   <= RST_GYRO_OFFSET[GYRO_BITS-1:0];
            sample_period_reg <= RST_SAMPLE_PERIOD;
            gain_angle_reg    <= RST_GAIN_ANGLE;
            gain_rate_reg     <= RST_GAIN_RATE;
            gain_position_reg <= RST_GAIN_POSITION;
            gain_velocity_reg <= RST_GAIN_VELOCITY;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_GYRO_OFFSET:   gyro_offset_reg   <= pwdata[GYRO_BITS-1:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[SP_W-1:0];
                REG_GAIN_ANGLE:    gain_angle_reg    <= pwdata;
                REG_GAIN_RATE:     gain_rate_reg     <= pwdata;
                REG_GAIN_POSITION: gain_position_reg <= pwdata;
                REG_GAIN_VELOCITY: gain_velocity_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_GYRO_OFFSET:   prdata = CFG_W'(gyro_offset_reg);
            REG_SAMPLE_PERIOD: prdata = CFG_W'(sample_period_reg);
            REG_GAIN_ANGLE:    prdata = gain_angle_reg;
            REG_GAIN_RATE:     prdata = gain_rate_reg;
            REG_GAIN_POSITION: prdata = gain_position_reg;
            REG_GAIN_VELOCITY: prdata = gain_velocity_reg;
            default:           prdata = '0;
        endcase
    end

    assign gyro_offset   = gyro_offset_reg;
    assign sample_period = sample_period_reg;
    assign gain_angle    = gain_angle_reg;
    assign gain_rate     = gain_rate_reg;
    assign gain_position = gain_position_reg;
    assign gain_velocity = gain_velocity_reg;

endmodule

[hw/rtl/bsf_ctrl.sv]
// bsf_ctrl: sequencer that steps the shared multiplier and accumulator
// depends on bsf_pkg
module bsf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bsf_pkg::bsf_status_t status,
    output bsf_pkg::bsf_cmd_t    cmd
);
    import bsf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MTILT = 4'd1;
    localparam logic [3:0] S_TILT = 4'd2;
    localparam logic [3:0] S_ATH  = 4'd3;
    localparam logic [3:0] S_ATL  = 4'd4;
    localparam logic [3:0] S_POS  = 4'd5;
    localparam logic [3:0] S_VEL  = 4'd6;
    localparam logic [3:0] S_LAST = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.acc_op    = ACC_HOLD;
        cmd.out_write = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MTILT;
                end
            end
            S_MTILT:
            begin
                cmd.mul_sel = MUL_RATE_SP;
                cmd.acc_op  = ACC_CLEAR;
                state_next  = S_TILT;
            end
            S_TILT:
            begin
                cmd.mul_sel = MUL_GR_RATE;
                cmd.acc_op  = ACC_TILT;
                state_next  = S_ATH;
            end
            S_ATH:
            begin
                cmd.mul_sel = MUL_GA_TH;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_ATL;
            end
            S_ATL:
            begin
                cmd.mul_sel = MUL_GA_TL;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_POS;
            end
            S_POS:
            begin
                cmd.mul_sel = MUL_GP_POS;
                cmd.acc_op  = ACC_ADDSH;
                state_next  = S_VEL;
            end
            S_VEL:
            begin
                cmd.mul_sel = MUL_GV_VEL;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_LAST;
            end
            S_LAST:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bsf_dpath.sv]
// bsf_dpath: tilt integrator, shared 33x33 multiplier, accumulator,
// clamp and output register; depends on bsf_pkg
module bsf_dpath #(
    parameter int GYRO_BITS  = bsf_pkg::GYRO_BITS_DEF,
    parameter int COUNT_BITS = bsf_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsf_pkg::bsf_cmd_t          cmd,
    output bsf_pkg::bsf_status_t       status,
    input  logic [GYRO_BITS-1:0]       gyro_raw,
    input  logic [COUNT_BITS-1:0]      encoder_count,
    input  logic [GYRO_BITS-1:0]       gyro_offset,
    input  logic [bsf_pkg::SP_W-1:0]   sample_period,
    input  logic [bsf_pkg::GAIN_W-1:0] gain_angle,
    input  logic [bsf_pkg::GAIN_W-1:0] gain_rate,
    input  logic [bsf_pkg::GAIN_W-1:0] gain_position,
    input  logic [bsf_pkg::GAIN_W-1:0] gain_velocity,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bsf_pkg::PCT_W-1:0]  speed_percent,
    output logic                       saturated
);
    import bsf_pkg::*;

    localparam logic signed [PROD_W-1:0] TILT_MAX =
        PROD_W'({1'b0, {(TILT_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] TILT_MIN = ~TILT_MAX;

    logic signed [GYRO_BITS:0]    rate_reg;
    logic signed [COUNT_BITS-1:0] pos_reg;
    logic signed [COUNT_BITS-1:0] vel_reg;
    logic [COUNT_BITS-1:0]        last_count_reg;
    logic signed [TILT_W-1:0]     tilt_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     acc_reg;
    logic signed [PROD_W-1:0]     acc_next;
    logic signed [TILT_W-1:0]     tilt_next;
    logic signed [PCT_W-1:0]      pct_reg;
    logic                         sat_reg;
    logic                         out_valid_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] mul_full;
    logic signed [PROD_W-1:0] tilt_sum;
    logic signed [PROD_W-1:0] acc_neg;
    logic [PCT_W-1:0]         mag;
    logic signed [PCT_W-1:0]  pct_next;
    logic                     sat_next;
    logic signed [GYRO_BITS:0] rate_in;

    assign rate_in = $signed({1'b0, gyro_raw}) - $signed({1'b0, gyro_offset});

    // operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MUL_RATE_SP:
            begin
                op_a = MUL_W'(rate_reg);
                op_b = $signed({{(MUL_W-SP_W){1'b0}}, sample_period});
            end
            MUL_GR_RATE:
            begin
                op_a = MUL_W'($signed(gain_rate));
                op_b = MUL_W'(rate_reg);
            end
            MUL_GA_TH:
            begin
                op_a = MUL_W'($signed(gain_angle));
                op_b = MUL_W'($signed(tilt_reg[TILT_W-1:FRAC_W]));
            end
            MUL_GA_TL:
            begin
                op_a = MUL_W'($signed(gain_angle));
                op_b = $signed({{(MUL_W-FRAC_W){1'b0}}, tilt_reg[FRAC_W-1:0]});
            end
            MUL_GP_POS:
            begin
                op_a = MUL_W'($signed(gain_position));
                op_b = MUL_W'(pos_reg);
            end
            MUL_GV_VEL:
            begin
                op_a = MUL_W'($signed(gain_velocity));
                op_b = MUL_W'(vel_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    // tilt integration, saturating at the 48 bit limits
    always_comb
    begin
        tilt_sum = PROD_W'(tilt_reg) + prod_reg;
        if (tilt_sum > TILT_MAX)
        begin
            tilt_next = TILT_MAX[TILT_W-1:0];
        end
        else if (tilt_sum < TILT_MIN)
        begin
            tilt_next = TILT_MIN[TILT_W-1:0];
        end
        else
        begin
            tilt_next = tilt_sum[TILT_W-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = acc_reg + prod_reg;
            ACC_ADDSH: acc_next = acc_reg + (prod_reg >>> FRAC_W);
            default:   acc_next = acc_reg;
        endcase
    end

    // clamp and truncate toward zero; exact wide sum keeps the clamp decision
    always_comb
    begin
        acc_neg = -acc_reg;
        mag     = acc_neg[Q16_W+PCT_W-1:Q16_W];
        if (acc_reg > LIMIT_Q16)
        begin
            pct_next = PCT_MAX;
            sat_next = 1'b1;
        end
        else if (acc_reg < -LIMIT_Q16)
        begin
            pct_next = PCT_MIN;
            sat_next = 1'b1;
        end
        else if (acc_reg >= 0)
        begin
            pct_next = acc_reg[Q16_W+PCT_W-1:Q16_W];
            sat_next = 1'b0;
        end
        else
        begin
            pct_next = $signed(PCT_W'(0) - mag);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_reg       <= '0;
            last_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_count_reg <= encoder_count;
            end
            if (cmd.acc_op == ACC_TILT)
            begin
                tilt_reg <= tilt_next;
            end
            if (cmd.out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;
        acc_reg  <= acc_next;
        if (cmd.load)
        begin
            rate_reg <= rate_in;
            pos_reg  <= $signed(encoder_count);
            vel_reg  <= $signed(encoder_count - last_count_reg);
        end
        if (cmd.out_write)
        begin
            pct_reg <= pct_next;
            sat_reg <= sat_next;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign speed_percent   = pct_reg;
    assign saturated       = sat_reg;

endmodule
